@@ sv/sprite_quad_transform_core_macros.svh @@
// Assertion helpers for the sprite quad transform core.
// Used by sprite_quad_transform_core.sv; assumes signals clk and rst_n in scope.
`ifndef SPRITE_QUAD_TRANSFORM_CORE_MACROS_SVH
`define SPRITE_QUAD_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SQT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SQT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sqt_pkg.sv @@
// Shared constants and the sine table generator for the sprite quad transform core.
// No dependencies; used by sprite_quad_transform_core.sv.
`default_nettype none

package sqt_pkg;

  localparam int POS_W   = 24;  // Q15.8 position fields
  localparam int PIV_W   = 25;  // position plus pivot offset
  localparam int TEX_W   = 16;
  localparam int UV_W    = 17;
  localparam int ANGLE_W = 16;
  localparam int TRIG_W  = 16;  // signed Q1.15
  localparam int ROM_W   = 15;  // magnitude of a table entry
  localparam int ROUND_SHIFT    = 15;
  localparam int ROUND_HALF_Q15 = 16384;

  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST  = 2'd3;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [1:0] corner_t;

  // One quarter-wave table entry: sin(idx / 2^tbits * pi/2) in Q1.15.
  // Eight-term Taylor series in Q2.30, each product truncated.
  function automatic logic [ROM_W-1:0] sine_entry(input int unsigned idx,
                                                  input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      r;
    x    = (64'(idx) * HALF_PI_Q30) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = (term * x2) >> 30;
      case (k)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    r = (sum + longint'(ROUND_HALF_Q15)) >>> ROUND_SHIFT;
    if (r > 32767) begin
      r = 32767;
    end
    if (r < 0) begin
      r = 0;
    end
    return r[ROM_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/sprite_quad_transform_core.sv @@
// Sprite quad transform core: one sprite in, four rotated and mirrored quad corners out.
// Depends on sqt_pkg.sv and sprite_quad_transform_core_macros.svh.
//
//   channel | direction | handshake         | moves
//   --------+-----------+-------------------+-------------------------------------
//   in_     | input     | in_valid/in_stall | one sprite request
//   out_    | output    | out_valid/out_stall | one corner per request, four per sprite
//
// The corner sequencer issues a sprite's four corners one after another, so a new
// sprite waits until the current one has issued its last corner.
// A corner passes the sprite register (where the table read lands on acceptance), then
// the product, round and output registers (multiply, round, and pivot add with saturate).
// The next sprite is taken in the cycle the last corner of the current one issues.
// A stalled output freezes the whole pipeline.
// Reset (rst_n low, synchronous) empties all stages; there is no clearing pass.
`default_nettype none
`include "sprite_quad_transform_core_macros.svh"

module sprite_quad_transform_core #(
  parameter int FRAC_BITS       = 8,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [sqt_pkg::POS_W-1:0]    in_pos_x,
  input  wire logic signed [sqt_pkg::POS_W-1:0]    in_pos_y,
  input  wire logic signed [sqt_pkg::POS_W-1:0]    in_pivot_dx,
  input  wire logic signed [sqt_pkg::POS_W-1:0]    in_pivot_dy,
  input  wire logic        [sqt_pkg::ANGLE_W-1:0]  in_angle,
  input  wire logic                                in_mirror_x,
  input  wire logic                                in_mirror_y,
  input  wire logic        [sqt_pkg::TEX_W-1:0]    in_tex_left,
  input  wire logic        [sqt_pkg::TEX_W-1:0]    in_tex_top,
  input  wire logic        [sqt_pkg::TEX_W-1:0]    in_tex_width,
  input  wire logic        [sqt_pkg::TEX_W-1:0]    in_tex_height,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [sqt_pkg::POS_W-1:0]         out_vert_x,
  output logic signed [sqt_pkg::POS_W-1:0]         out_vert_y,
  output logic        [sqt_pkg::UV_W-1:0]          out_tex_u,
  output logic        [sqt_pkg::UV_W-1:0]          out_tex_v,
  output logic        [1:0]                        out_corner,
  output logic                                     out_last
);

  localparam int N      = 1 << TRIG_TABLE_BITS;
  localparam int IDX_W  = TRIG_TABLE_BITS + 1;
  localparam int WQ_W   = sqt_pkg::TEX_W + FRAC_BITS;
  localparam int DW     = ((WQ_W > sqt_pkg::POS_W - 1) ? WQ_W : sqt_pkg::POS_W - 1) + 2;
  localparam int PW     = DW + sqt_pkg::TRIG_W;
  localparam int RW     = PW + 1 - sqt_pkg::ROUND_SHIFT;
  localparam int CW     = sqt_pkg::PIV_W;
  localparam int SW     = ((RW > CW) ? RW : CW) + 1;
  localparam int ROM_W  = sqt_pkg::ROM_W;
  localparam int POS_W  = sqt_pkg::POS_W;
  localparam int UV_W   = sqt_pkg::UV_W;

  localparam logic signed [PW:0] ROUND_HALF = (PW + 1)'(sqt_pkg::ROUND_HALF_Q15);

  typedef logic [ROM_W-1:0] rom_t [0:N];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int i = 0; i <= N; i++) begin
      rom[i] = sqt_pkg::sine_entry(unsigned'(i), unsigned'(TRIG_TABLE_BITS));
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Saturate a widened sum back to the signed Q15.8 range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SW-1:0] v);
    logic [SW-POS_W:0] top;
    top = v[SW-1:POS_W-1];
    if ((&top) || !(|top)) begin
      return v[POS_W-1:0];
    end else if (v[SW-1]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  // ---------------------------------------------------------------- control
  logic en;
  logic in_acc;
  logic s1_issue;

  logic                 s1_valid_r, s1_valid_nxt;
  sqt_pkg::corner_t     s1_corner_r, s1_corner_nxt;
  logic                 m_valid_r;
  logic                 r_valid_r;
  logic                 out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign s1_issue = en && s1_valid_r;
  assign in_stall = !(en && (!s1_valid_r || s1_corner_r == sqt_pkg::CORNER_LAST));
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_corner_nxt = s1_corner_r;
    if (in_acc) begin
      s1_valid_nxt  = 1'b1;
      s1_corner_nxt = sqt_pkg::CORNER_FIRST;
    end else if (s1_issue) begin
      s1_corner_nxt = s1_corner_r + 2'd1;
      if (s1_corner_r == sqt_pkg::CORNER_LAST) begin
        s1_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_corner_r <= sqt_pkg::CORNER_FIRST;
      m_valid_r   <= 1'b0;
      r_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s1_corner_r <= s1_corner_nxt;
      if (en) begin
        m_valid_r   <= s1_valid_r;
        r_valid_r   <= m_valid_r;
        out_valid_r <= r_valid_r;
      end
    end
  end

  // ------------------------------------------------ angle decode, table read
  logic [1:0]                 quad;
  logic [TRIG_TABLE_BITS-1:0] step;
  logic [IDX_W-1:0]           idx_fwd, idx_rev, sin_idx, cos_idx;

  always_comb begin
    quad    = in_angle[sqt_pkg::ANGLE_W-1 -: 2];
    step    = in_angle[sqt_pkg::ANGLE_W-3 -: TRIG_TABLE_BITS];
    idx_fwd = {1'b0, step};
    idx_rev = IDX_W'(N) - idx_fwd;
    sin_idx = quad[0] ? idx_rev : idx_fwd;
    cos_idx = quad[0] ? idx_fwd : idx_rev;
  end

  // ------------------------------------------------ stage 1: sprite register
  logic signed [POS_W-1:0]         s1_pdx_r, s1_pdy_r;
  logic signed [CW-1:0]            s1_cx_r, s1_cy_r;
  logic                            s1_mx_r, s1_my_r;
  logic [sqt_pkg::TEX_W-1:0]       s1_tl_r, s1_tt_r, s1_tw_r, s1_th_r;
  logic [ROM_W-1:0]                s1_sin_mag_r, s1_cos_mag_r;
  logic                            s1_sin_neg_r, s1_cos_neg_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pdx_r     <= in_pivot_dx;
      s1_pdy_r     <= in_pivot_dy;
      s1_cx_r      <= CW'(in_pos_x) + CW'(in_pivot_dx);
      s1_cy_r      <= CW'(in_pos_y) + CW'(in_pivot_dy);
      s1_mx_r      <= in_mirror_x;
      s1_my_r      <= in_mirror_y;
      s1_tl_r      <= in_tex_left;
      s1_tt_r      <= in_tex_top;
      s1_tw_r      <= in_tex_width;
      s1_th_r      <= in_tex_height;
      s1_sin_mag_r <= SINE_ROM[sin_idx];
      s1_cos_mag_r <= SINE_ROM[cos_idx];
      s1_sin_neg_r <= quad[1];
      s1_cos_neg_r <= quad[1] ^ quad[0];
    end
  end

  // Offset of the corner from the pivot. Mirroring about the pivot just
  // negates that offset.
  logic                          right_col, bottom_row;
  logic signed [DW-1:0]          wq, hq, off_x, off_y, dx, dy;
  logic signed [sqt_pkg::TRIG_W-1:0] sin_v, cos_v;
  logic signed [PW-1:0]          xc, ys, xs, yc;
  logic [UV_W-1:0]               u_nxt, v_nxt;

  always_comb begin
    right_col  = s1_corner_r[0] ^ s1_corner_r[1];
    bottom_row = !s1_corner_r[1];
    wq    = $signed(DW'(s1_tw_r)) <<< FRAC_BITS;
    hq    = $signed(DW'(s1_th_r)) <<< FRAC_BITS;
    off_x = (right_col ? wq : DW'(0)) - DW'(s1_pdx_r);
    off_y = (bottom_row ? hq : DW'(0)) - DW'(s1_pdy_r);
    dx    = s1_mx_r ? -off_x : off_x;
    dy    = s1_my_r ? -off_y : off_y;
    sin_v = s1_sin_neg_r ? -$signed({1'b0, s1_sin_mag_r}) : $signed({1'b0, s1_sin_mag_r});
    cos_v = s1_cos_neg_r ? -$signed({1'b0, s1_cos_mag_r}) : $signed({1'b0, s1_cos_mag_r});
    xc    = dx * cos_v;
    ys    = dy * sin_v;
    xs    = dx * sin_v;
    yc    = dy * cos_v;
    u_nxt = UV_W'(s1_tl_r) + (right_col ? UV_W'(s1_tw_r) : UV_W'(0));
    v_nxt = UV_W'(s1_tt_r) + (s1_corner_r[1] ? UV_W'(s1_th_r) : UV_W'(0));
  end

  // ------------------------------------------------ stage M: products
  logic signed [PW-1:0]   m_xc_r, m_ys_r, m_xs_r, m_yc_r;
  logic signed [CW-1:0]   m_cx_r, m_cy_r;
  logic [UV_W-1:0]        m_u_r, m_v_r;
  sqt_pkg::corner_t       m_corner_r;
  logic                   m_last_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m_xc_r     <= xc;
      m_ys_r     <= ys;
      m_xs_r     <= xs;
      m_yc_r     <= yc;
      m_cx_r     <= s1_cx_r;
      m_cy_r     <= s1_cy_r;
      m_u_r      <= u_nxt;
      m_v_r      <= v_nxt;
      m_corner_r <= s1_corner_r;
      m_last_r   <= (s1_corner_r == sqt_pkg::CORNER_LAST);
    end
  end

  // ------------------------------------------------ stage R: round half up
  logic signed [PW:0] acc_x, acc_y;

  always_comb begin
    acc_x = $signed({m_xc_r[PW-1], m_xc_r}) - $signed({m_ys_r[PW-1], m_ys_r}) + ROUND_HALF;
    acc_y = $signed({m_xs_r[PW-1], m_xs_r}) + $signed({m_yc_r[PW-1], m_yc_r}) + ROUND_HALF;
  end

  logic signed [RW-1:0]   r_rx_r, r_ry_r;
  logic signed [CW-1:0]   r_cx_r, r_cy_r;
  logic [UV_W-1:0]        r_u_r, r_v_r;
  sqt_pkg::corner_t       r_corner_r;
  logic                   r_last_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r_rx_r     <= acc_x[PW:sqt_pkg::ROUND_SHIFT];
      r_ry_r     <= acc_y[PW:sqt_pkg::ROUND_SHIFT];
      r_cx_r     <= m_cx_r;
      r_cy_r     <= m_cy_r;
      r_u_r      <= m_u_r;
      r_v_r      <= m_v_r;
      r_corner_r <= m_corner_r;
      r_last_r   <= m_last_r;
    end
  end

  // ------------------------------------------------ output: pivot add, saturate
  logic signed [SW-1:0] sum_x, sum_y;

  always_comb begin
    sum_x = $signed({{(SW - CW){r_cx_r[CW-1]}}, r_cx_r})
          + $signed({{(SW - RW){r_rx_r[RW-1]}}, r_rx_r});
    sum_y = $signed({{(SW - CW){r_cy_r[CW-1]}}, r_cy_r})
          + $signed({{(SW - RW){r_ry_r[RW-1]}}, r_ry_r});
  end

  logic signed [POS_W-1:0] out_x_r, out_y_r;
  logic [UV_W-1:0]         out_u_r, out_v_r;
  sqt_pkg::corner_t        out_corner_r;
  logic                    out_last_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r      <= sat_pos(sum_x);
      out_y_r      <= sat_pos(sum_y);
      out_u_r      <= r_u_r;
      out_v_r      <= r_v_r;
      out_corner_r <= r_corner_r;
      out_last_r   <= r_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_vert_x = out_x_r;
  assign out_vert_y = out_y_r;
  assign out_tex_u  = out_u_r;
  assign out_tex_v  = out_v_r;
  assign out_corner = out_corner_r;
  assign out_last   = out_last_r;

  // ------------------------------------------------ assertions
  `SQT_ASSERT_NOW(a_no_overwrite, in_valid && !in_stall,
    !s1_valid_r || s1_corner_r == sqt_pkg::CORNER_LAST, "sprite request overwrote a busy sprite")
  `SQT_ASSERT_NEXT(a_corner_follows, out_valid && !out_stall && !out_last,
    out_valid && out_corner == $past(out_corner) + 2'd1, "quad corners not emitted back to back")
  `SQT_ASSERT_NOW(a_last_on_fourth, out_valid,
    out_last == (out_corner == sqt_pkg::CORNER_LAST), "last flag not on the fourth corner")

endmodule

`default_nettype wire

@@ sim/sprite_quad_transform_core_tb.sv @@
// Self-checking testbench for sprite_quad_transform_core: sprites in, four checked corners out.
// Depends on sqt_pkg.sv and the core RTL; the expected corners come from a predictor written here.
`timescale 1ns / 100ps

module sprite_quad_transform_core_tb;

  localparam int FRAC  = 8;
  localparam int TBITS = 10;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

  typedef struct {
    logic signed [sqt_pkg::POS_W-1:0] pos_x;
    logic signed [sqt_pkg::POS_W-1:0] pos_y;
    logic signed [sqt_pkg::POS_W-1:0] pivot_dx;
    logic signed [sqt_pkg::POS_W-1:0] pivot_dy;
    logic [sqt_pkg::ANGLE_W-1:0]      angle;
    logic                             mirror_x;
    logic                             mirror_y;
    logic [sqt_pkg::TEX_W-1:0]        tex_left;
    logic [sqt_pkg::TEX_W-1:0]        tex_top;
    logic [sqt_pkg::TEX_W-1:0]        tex_width;
    logic [sqt_pkg::TEX_W-1:0]        tex_height;
  } sprite_t;

  typedef struct {
    logic signed [sqt_pkg::POS_W-1:0] vert_x;
    logic signed [sqt_pkg::POS_W-1:0] vert_y;
    logic [sqt_pkg::UV_W-1:0]         tex_u;
    logic [sqt_pkg::UV_W-1:0]         tex_v;
    logic [1:0]                       corner;
    logic                             last;
  } quad_vertex_t;

  typedef enum {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  class corner_scoreboard;
    logic [14:0]  sine_rom [0:(1 << TBITS)];
    quad_vertex_t expected_corners[$];
    int unsigned  corners_checked;

    // Quarter-wave table: Taylor series in Q2.30 with truncated products,
    // rounded to Q1.15 and clamped so a quarter turn gives 32767.
    function new();
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      acc;
      longint      r;
      corners_checked = 0;
      for (int i = 0; i <= (1 << TBITS); i++) begin
        x    = (64'(i) * QUARTER_TURN_Q30) >> TBITS;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
          term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
          if (n % 2 == 1) begin
            acc = acc - longint'(term);
          end else begin
            acc = acc + longint'(term);
          end
        end
        r = (acc + 16384) >>> 15;
        if (r > 32767) begin
          r = 32767;
        end
        if (r < 0) begin
          r = 0;
        end
        sine_rom[i] = 15'(r);
      end
    endfunction

    function longint sine_q15(logic [15:0] a);
      int unsigned k;
      int unsigned idx;
      k   = a[13:0] >> (14 - TBITS);
      idx = a[14] ? (1 << TBITS) - k : k;
      return a[15] ? -longint'(sine_rom[idx]) : longint'(sine_rom[idx]);
    endfunction

    function logic [23:0] clamp_pos(longint v);
      if (v > 8388607) begin
        return 24'h7FFFFF;
      end
      if (v < -8388608) begin
        return 24'h800000;
      end
      return 24'(v);
    endfunction

    function void predict_corners(sprite_t s);
      longint       piv_x, piv_y, wq, hq, vx, vy, dx, dy, sn, cs;
      logic [15:0]  cos_angle;
      quad_vertex_t v;
      bit           right, low;
      piv_x     = longint'(s.pos_x) + longint'(s.pivot_dx);
      piv_y     = longint'(s.pos_y) + longint'(s.pivot_dy);
      wq        = longint'(s.tex_width) << FRAC;
      hq        = longint'(s.tex_height) << FRAC;
      cos_angle = s.angle + 16'h4000;
      sn        = sine_q15(s.angle);
      cs        = sine_q15(cos_angle);
      for (int k = 0; k < 4; k++) begin
        right = (k == 1) || (k == 2);
        low   = (k < 2);
        vx    = longint'(s.pos_x);
        vy    = longint'(s.pos_y);
        if (right) begin
          vx = vx + wq;
        end
        if (low) begin
          vy = vy + hq;
        end
        if (s.mirror_x) begin
          vx = 2 * piv_x - vx;
        end
        if (s.mirror_y) begin
          vy = 2 * piv_y - vy;
        end
        dx = vx - piv_x;
        dy = vy - piv_y;
        // Round half up to FRAC fraction bits, then add the pivot back.
        v.vert_x = clamp_pos(piv_x + ((dx * cs - dy * sn + 16384) >>> 15));
        v.vert_y = clamp_pos(piv_y + ((dx * sn + dy * cs + 16384) >>> 15));
        v.tex_u  = 17'(s.tex_left) + (right ? 17'(s.tex_width) : 17'd0);
        v.tex_v  = 17'(s.tex_top) + ((k >= 2) ? 17'(s.tex_height) : 17'd0);
        v.corner = 2'(k);
        v.last   = (2'(k) == sqt_pkg::CORNER_LAST);
        expected_corners.push_back(v);
      end
    endfunction

    function bit check_corner(quad_vertex_t got, output string why);
      quad_vertex_t want;
      why = "";
      if (expected_corners.size() == 0) begin
        why = "corner arrived with no sprite request pending";
        return 0;
      end
      want = expected_corners.pop_front();
      if (got.vert_x !== want.vert_x) begin
        why = {why, $sformatf(" vert_x %0d/%0d", got.vert_x, want.vert_x)};
      end
      if (got.vert_y !== want.vert_y) begin
        why = {why, $sformatf(" vert_y %0d/%0d", got.vert_y, want.vert_y)};
      end
      if (got.tex_u !== want.tex_u) begin
        why = {why, $sformatf(" tex_u %0d/%0d", got.tex_u, want.tex_u)};
      end
      if (got.tex_v !== want.tex_v) begin
        why = {why, $sformatf(" tex_v %0d/%0d", got.tex_v, want.tex_v)};
      end
      if (got.corner !== want.corner) begin
        why = {why, $sformatf(" corner %0d/%0d", got.corner, want.corner)};
      end
      if (got.last !== want.last) begin
        why = {why, $sformatf(" last %0d/%0d", got.last, want.last)};
      end
      if (why != "") begin
        why = {$sformatf("sprite %0d corner %0d (got/expected):", corners_checked / 4,
                         want.corner), why};
      end
      corners_checked++;
      return why == "";
    endfunction

    function int pending();
      return expected_corners.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] in_pos_x = '0;
  logic signed [23:0] in_pos_y = '0;
  logic signed [23:0] in_pivot_dx = '0;
  logic signed [23:0] in_pivot_dy = '0;
  logic [15:0] in_angle = '0;
  logic in_mirror_x = 1'b0;
  logic in_mirror_y = 1'b0;
  logic [15:0] in_tex_left = '0;
  logic [15:0] in_tex_top = '0;
  logic [15:0] in_tex_width = '0;
  logic [15:0] in_tex_height = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] out_vert_x;
  logic signed [23:0] out_vert_y;
  logic [16:0] out_tex_u;
  logic [16:0] out_tex_v;
  logic [1:0] out_corner;
  logic out_last;

  corner_scoreboard corners;
  int sprites_in = 0;
  int corners_out = 0;
  int stalled_offers = 0;
  int mismatches = 0;

  sprite_quad_transform_core #(
    .FRAC_BITS(FRAC),
    .TRIG_TABLE_BITS(TBITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_pivot_dx(in_pivot_dx),
    .in_pivot_dy(in_pivot_dy),
    .in_angle(in_angle),
    .in_mirror_x(in_mirror_x),
    .in_mirror_y(in_mirror_y),
    .in_tex_left(in_tex_left),
    .in_tex_top(in_tex_top),
    .in_tex_width(in_tex_width),
    .in_tex_height(in_tex_height),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_vert_x(out_vert_x),
    .out_vert_y(out_vert_y),
    .out_tex_u(out_tex_u),
    .out_tex_v(out_tex_v),
    .out_corner(out_corner),
    .out_last(out_last)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 20) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Holds the request on the port until the edge that accepts it.
  task automatic offer_sprite(input sprite_t s);
    in_valid      <= 1'b1;
    in_pos_x      <= s.pos_x;
    in_pos_y      <= s.pos_y;
    in_pivot_dx   <= s.pivot_dx;
    in_pivot_dy   <= s.pivot_dy;
    in_angle      <= s.angle;
    in_mirror_x   <= s.mirror_x;
    in_mirror_y   <= s.mirror_y;
    in_tex_left   <= s.tex_left;
    in_tex_top    <= s.tex_top;
    in_tex_width  <= s.tex_width;
    in_tex_height <= s.tex_height;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  function automatic sprite_t make_sprite(logic [23:0] px, logic [23:0] py, logic [23:0] pdx,
                                          logic [23:0] pdy, logic [15:0] ang, logic mx,
                                          logic my, logic [15:0] tl, logic [15:0] tt,
                                          logic [15:0] tw, logic [15:0] th);
    sprite_t s;
    s.pos_x      = px;
    s.pos_y      = py;
    s.pivot_dx   = pdx;
    s.pivot_dy   = pdy;
    s.angle      = ang;
    s.mirror_x   = mx;
    s.mirror_y   = my;
    s.tex_left   = tl;
    s.tex_top    = tt;
    s.tex_width  = tw;
    s.tex_height = th;
    return s;
  endfunction

  function automatic logic [23:0] pick_pos();
    case ($urandom_range(0, 5))
      0:       return 24'h7FFFFF - 24'($urandom_range(0, 4095));
      1:       return 24'h800000 + 24'($urandom_range(0, 4095));
      2:       return 24'(int'($urandom_range(0, 131071)) - 65536);
      3:       return 24'd0;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return 16'($urandom_range(0, 64));
      4:          return 16'($urandom_range(0, 4095));
      5:          return 16'hFFFF;
      default:    return 16'($urandom);
    endcase
  endfunction

  function automatic sprite_t random_sprite();
    sprite_t s;
    s.pos_x = pick_pos();
    s.pos_y = pick_pos();
    // Pivots are mostly near the sprite, sometimes anywhere.
    if ($urandom_range(0, 2) != 0) begin
      s.pivot_dx = 24'(int'($urandom_range(0, 32767)) - 16384);
      s.pivot_dy = 24'(int'($urandom_range(0, 32767)) - 16384);
    end else begin
      s.pivot_dx = pick_pos();
      s.pivot_dy = pick_pos();
    end
    // Some angles sit just around the quadrant boundaries.
    if ($urandom_range(0, 3) == 0) begin
      s.angle = {2'($urandom), 14'd0} + 16'($urandom_range(0, 31)) - 16'd16;
    end else begin
      s.angle = 16'($urandom);
    end
    s.mirror_x   = 1'($urandom);
    s.mirror_y   = 1'($urandom);
    s.tex_left   = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
    s.tex_top    = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
    s.tex_width  = pick_size();
    s.tex_height = pick_size();
    return s;
  endfunction

  always @(posedge clk) begin : request_monitor
    sprite_t s;
    if (rst_n && in_valid) begin
      if (in_stall) begin
        stalled_offers++;
      end else begin
        s.pos_x      = in_pos_x;
        s.pos_y      = in_pos_y;
        s.pivot_dx   = in_pivot_dx;
        s.pivot_dy   = in_pivot_dy;
        s.angle      = in_angle;
        s.mirror_x   = in_mirror_x;
        s.mirror_y   = in_mirror_y;
        s.tex_left   = in_tex_left;
        s.tex_top    = in_tex_top;
        s.tex_width  = in_tex_width;
        s.tex_height = in_tex_height;
        corners.predict_corners(s);
        sprites_in++;
      end
    end
  end

  always @(posedge clk) begin : corner_monitor
    quad_vertex_t got;
    string        why;
    if (rst_n && out_valid && !out_stall) begin
      got.vert_x = out_vert_x;
      got.vert_y = out_vert_y;
      got.tex_u  = out_tex_u;
      got.tex_v  = out_tex_v;
      got.corner = out_corner;
      got.last   = out_last;
      if (!corners.check_corner(got, why)) begin
        report_mismatch(why);
      end
      corners_out++;
    end
  end

  // Output side: stall patterns in random spans, plus one long hold-off once
  // traffic is flowing so the pipeline backs up into the input.
  initial begin : receiver
    stall_mode_t mode;
    int          span;
    int unsigned tick;
    bit          held_off;
    tick     = 0;
    held_off = 0;
    while (!rst_n) begin
      @(posedge clk);
    end
    forever begin
      if (!held_off && sprites_in >= 60) begin
        held_off = 1;
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
      end
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(10, 60);
      repeat (span) begin
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
          STALL_PERIODIC: out_stall <= ((tick % 7) < 3);
          default:        out_stall <= ($urandom_range(0, 9) < 7);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    sprite_t plan[$];
    int      burst;
    int      gap;
    int      idx;
    int      directed;
    corners = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan.push_back(make_sprite(0, 0, 0, 0, 16'd0, 0, 0, 0, 0, 0, 0));
    plan.push_back(make_sprite(0, 0, 0, 0, 16'd0, 0, 0, 0, 0, 1, 1));
    plan.push_back(make_sprite(24'h000100, 24'h000200, 0, 0, 16'd16384, 0, 0, 10, 20, 16, 8));
    plan.push_back(make_sprite(24'h000100, 24'h000200, 0, 0, 16'd32768, 0, 0, 10, 20, 16, 8));
    plan.push_back(make_sprite(24'h000100, 24'h000200, 0, 0, 16'd49152, 0, 0, 10, 20, 16, 8));
    plan.push_back(make_sprite(24'h000100, 24'h000200, 0, 0, 16'd65535, 0, 0, 10, 20, 16, 8));
    plan.push_back(make_sprite(24'h001000, 24'h002000, 24'h000800, 24'h000400, 16'd8192,
                               0, 0, 3, 4, 16, 8));
    plan.push_back(make_sprite(24'h001000, 24'h002000, 24'h000300, 24'h000100, 16'd0,
                               1, 0, 3, 4, 16, 8));
    plan.push_back(make_sprite(24'h001000, 24'h002000, 24'h000300, 24'h000100, 16'd0,
                               0, 1, 3, 4, 16, 8));
    plan.push_back(make_sprite(24'hFFF000, 24'h002000, 24'h000300, 24'hFFFF00, 16'd12345,
                               1, 1, 3, 4, 40, 24));
    // Corners at or beyond the ends of the position range, and texture sums at their top.
    plan.push_back(make_sprite(24'h7FFFFF, 24'h7FFFFF, 0, 0, 16'd0, 0, 0,
                               16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    plan.push_back(make_sprite(24'h800000, 24'h800000, 24'h800000, 24'h800000, 16'd32768,
                               1, 1, 0, 0, 16'hFFFF, 16'hFFFF));
    plan.push_back(make_sprite(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'd40000,
                               1, 0, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF));
    // Table index at its ends, and lower angle bits that get truncated.
    plan.push_back(make_sprite(24'h000000, 24'h000000, 0, 0, 16'd16383, 0, 0, 0, 0, 64, 32));
    plan.push_back(make_sprite(24'h000000, 24'h000000, 0, 0, 16'd16, 0, 0, 0, 0, 64, 32));
    plan.push_back(make_sprite(24'h000000, 24'h000000, 0, 0, 16'd15, 0, 0, 0, 0, 64, 32));
    plan.push_back(make_sprite(24'h000000, 24'h000000, 0, 0, 16'd16400, 0, 0, 0, 0, 64, 32));
    plan.push_back(make_sprite(0, 0, 24'h800000, 24'h7FFFFF, 16'd16384, 1, 0, 0, 0, 300, 300));
    plan.push_back(make_sprite(24'h123456, 24'hEDCBA9, 24'h000080, 24'hFFFF80, 16'd24576,
                               0, 1, 16'hFFFF, 0, 1, 16'hFFFF));
    directed = plan.size();

    repeat (410) plan.push_back(random_sprite());

    idx = 0;
    while (idx < plan.size()) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      while (burst > 0 && idx < plan.size()) begin
        offer_sprite(plan[idx]);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (corners.pending() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);

    $display("Sent %0d sprites (%0d directed, rest random) and checked %0d corners.",
             sprites_in, directed, corners_out);
    $display("Requests were held back on %0d offered cycles, one long output hold-off included.",
             stalled_offers);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
